// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the step pattern gate envelope RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define SPGE_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define SPGE_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPGE_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg)
`define SPGE_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg)
`endif

`endif

// ===== hdl/spge_pkg.sv =====
// Shared types, constants and microcode encodings for the step pattern gate envelope.
package spge_pkg;

  // Field and register widths
  localparam int IDX_W      = 32;
  localparam int LEN_W      = 24;
  localparam int CNT_W      = 5;
  localparam int PAT_W      = 16;
  localparam int BLUR_W     = 17;
  localparam int GAIN_W     = 16;
  localparam int SEG_OUT_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int MAX_SEGMENTS_DEF = 16;

  // Register reset values
  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(48000);
  localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(16);
  localparam logic [PAT_W-1:0]  PAT_RESET  = '1;
  localparam logic [BLUR_W-1:0] BLUR_RESET = BLUR_W'(66);

  // Gain scale and blur floor (66/65536, about one thousandth)
  localparam logic [GAIN_W-1:0] UNITY      = GAIN_W'(32768);
  localparam logic [BLUR_W-1:0] BLUR_FLOOR = BLUR_W'(66);

  // Divider geometry
  localparam int DVD_W      = IDX_W;
  localparam int PN_W       = LEN_W + CNT_W;
  localparam int DEN_W      = LEN_W + BLUR_W;
  localparam int STEP_W     = $clog2(DVD_W + 1);
  localparam int RAMP_FRAC  = 31;
  localparam int STEPS_RAMP = 25;
  localparam int RAMP_PRE   = RAMP_FRAC - STEPS_RAMP;

  // Sequencer
  localparam int PC_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAT_LENGTH,
    CFG_SEGMENT_COUNT,
    CFG_PATTERN,
    CFG_BLUR
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_BRANCH,
    SEQ_WAIT
  } seq_mode_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN,
    COND_LEN_ZERO,
    COND_CNT_ZERO,
    COND_WID_ZERO,
    COND_DIV_DONE,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_DIV_PHASE,
    OP_ST_PHASE,
    OP_MUL_PN,
    OP_DIV_SEG,
    OP_ST_SEG,
    OP_DIV_WID,
    OP_ST_WID,
    OP_DIV_OFS,
    OP_ST_OFS,
    OP_MUL_WB,
    OP_DIV_RAMP,
    OP_ST_RAMP,
    OP_EMIT_GATE,
    OP_EMIT_OPEN
  } op_t;

  typedef struct packed {
    seq_mode_t        mode;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    op_t              op;
  } ucode_t;

  typedef struct packed {
    op_t  op;
    logic fire;
  } ctrl_t;

  typedef struct packed {
    logic len_zero;
    logic cnt_zero;
    logic wid_zero;
    logic div_done;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [IDX_W-1:0] sample_index;
    logic             resync;
  } in_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]    gain;
    logic [SEG_OUT_W-1:0] segment;
    logic                 segment_changed;
  } out_item_t;

endpackage

// ===== hdl/spge_div.sv =====
// Restoring divider, one quotient bit per cycle, with preloadable remainder.
module spge_div
  import spge_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DEN_W-1:0]  rem_init,
  input  logic [DVD_W-1:0]  dvd_init,
  input  logic [DEN_W-1:0]  den,
  input  logic [STEP_W-1:0] steps,
  output logic [DVD_W-1:0]  quo,
  output logic [DEN_W-1:0]  rem,
  output logic              done
);

  logic [STEP_W-1:0] cnt_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = ~diff[DEN_W];

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= steps;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - STEP_W'(1);
    end
  end

  // Load operands or advance one bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dvd_r <= dvd_init;
      den_r <= den;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = (cnt_r == '0);

endmodule

// ===== hdl/spge_dp.sv =====
// Datapath: configuration, beat state, operand registers, divider and result register.
module spge_dp
  import spge_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_t                 ctrl,
  output status_t               status,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  logic [LEN_W-1:0]     len_r;
  logic [CNT_W-1:0]     count_r;
  logic [PAT_W-1:0]     pattern_r;
  logic [BLUR_W-1:0]    blur_r;
  logic [IDX_W-1:0]     anchor_r;
  logic [SEG_OUT_W-1:0] last_seg_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 rs_r;
  logic [LEN_W-1:0]     phase_r;
  logic [CNT_W-1:0]     seg_r;
  logic [LEN_W-1:0]     w_r;
  logic [LEN_W-1:0]     offset_r;
  logic [GAIN_W-1:0]    q_r;
  logic [DEN_W-1:0]     prod_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  out_item_t            out_data_r;

  logic [CNT_W-1:0]  n;
  logic [BLUR_W-1:0] b;
  logic [PN_W-1:0]   pn;
  logic [DEN_W-1:0]  wb;
  logic [CNT_W-1:0]  prev_seg;
  logic              cur_bit;
  logic              prev_bit;
  logic [GAIN_W-1:0] gain;
  logic              emit;
  logic              out_free;

  logic              div_start;
  logic [DEN_W-1:0]  div_rem_init;
  logic [DVD_W-1:0]  div_dvd_init;
  logic [DEN_W-1:0]  div_den;
  logic [STEP_W-1:0] div_steps;
  logic [DVD_W-1:0]  div_quo;
  logic [DEN_W-1:0]  div_rem;
  logic              div_done;

  // Segment count clamped to the supported maximum, blur floored
  assign n = (int'(count_r) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : count_r;
  assign b = (blur_r < BLUR_FLOOR) ? BLUR_FLOOR : blur_r;

  // Products, each stored in prod_r before use
  assign pn = PN_W'(phase_r) * PN_W'(n);
  assign wb = DEN_W'(w_r) * DEN_W'(b);

  // Pattern lookup, segment zero wraps to the last segment in use
  function automatic logic pattern_bit(logic [PAT_W-1:0] pat, logic [CNT_W-1:0] idx);
    logic bit_val;
    bit_val = 1'b0;
    if (idx < CNT_W'(PAT_W)) begin
      bit_val = pat[idx[$clog2(PAT_W)-1:0]];
    end
    return bit_val;
  endfunction

  assign prev_seg = (seg_r == '0) ? (n - CNT_W'(1)) : (seg_r - CNT_W'(1));
  assign cur_bit  = pattern_bit(pattern_r, seg_r);
  assign prev_bit = pattern_bit(pattern_r, prev_seg);

  always_comb begin
    if (cur_bit) begin
      gain = prev_bit ? UNITY : q_r;
    end else begin
      gain = prev_bit ? (UNITY - q_r) : '0;
    end
  end

  // Select divider operands for the current step
  always_comb begin
    div_start    = 1'b0;
    div_rem_init = '0;
    div_dvd_init = '0;
    div_den      = DEN_W'(len_r);
    div_steps    = '0;
    case (ctrl.op)
      OP_DIV_PHASE: begin
        div_start    = ctrl.fire;
        div_dvd_init = idx_r - anchor_r;
        div_steps    = STEP_W'(IDX_W);
      end
      OP_DIV_SEG: begin
        div_start    = ctrl.fire;
        div_dvd_init = {prod_r[PN_W-1:0], {(DVD_W-PN_W){1'b0}}};
        div_steps    = STEP_W'(PN_W);
      end
      OP_DIV_WID: begin
        div_start    = ctrl.fire;
        div_dvd_init = {len_r, {(DVD_W-LEN_W){1'b0}}};
        div_den      = DEN_W'(n);
        div_steps    = STEP_W'(LEN_W);
      end
      OP_DIV_OFS: begin
        div_start    = ctrl.fire;
        div_dvd_init = {phase_r, {(DVD_W-LEN_W){1'b0}}};
        div_den      = DEN_W'(w_r);
        div_steps    = STEP_W'(LEN_W);
      end
      OP_DIV_RAMP: begin
        // Upper quotient bits are known zero: start from offset << RAMP_PRE
        div_start    = ctrl.fire;
        div_rem_init = DEN_W'({offset_r, {RAMP_PRE{1'b0}}});
        div_den      = prod_r;
        div_steps    = STEP_W'(STEPS_RAMP);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  spge_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem_init),
    .dvd_init (div_dvd_init),
    .den      (div_den),
    .steps    (div_steps),
    .quo      (div_quo),
    .rem      (div_rem),
    .done     (div_done)
  );

  // Configuration registers and beat state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= LEN_RESET;
      count_r    <= CNT_RESET;
      pattern_r  <= PAT_RESET;
      blur_r     <= BLUR_RESET;
      anchor_r   <= '0;
      last_seg_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_BEAT_LENGTH:   len_r     <= cfg_data[LEN_W-1:0];
          CFG_SEGMENT_COUNT: count_r   <= cfg_data[CNT_W-1:0];
          CFG_PATTERN:       pattern_r <= cfg_data[PAT_W-1:0];
          CFG_BLUR:          blur_r    <= cfg_data[BLUR_W-1:0];
          default:           len_r     <= len_r;
        endcase
      end
      if (ctrl.fire && ctrl.op == OP_ST_PHASE && rs_r) begin
        anchor_r <= idx_r;
      end
      if (ctrl.fire && ctrl.op == OP_EMIT_GATE) begin
        last_seg_r <= seg_r[SEG_OUT_W-1:0];
      end
    end
  end

  // Operand registers, written by the step that owns them
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      case (ctrl.op)
        OP_CAPTURE: begin
          idx_r <= in_data.sample_index;
          rs_r  <= in_data.resync;
        end
        OP_ST_PHASE: phase_r  <= div_rem[LEN_W-1:0];
        OP_MUL_PN:   prod_r   <= DEN_W'(pn);
        OP_ST_SEG:   seg_r    <= div_quo[CNT_W-1:0];
        OP_ST_WID: begin
          w_r <= div_quo[LEN_W-1:0];
          q_r <= UNITY;
        end
        OP_ST_OFS:   offset_r <= div_rem[LEN_W-1:0];
        OP_MUL_WB:   prod_r   <= wb;
        OP_ST_RAMP:  q_r      <= (div_quo > DVD_W'(UNITY)) ? UNITY : div_quo[GAIN_W-1:0];
        default:     rs_r     <= rs_r;
      endcase
    end
  end

  // Result register: load on emit, drop once taken
  assign out_free = ~out_valid_r | ~out_stall;
  assign emit = ctrl.fire && (ctrl.op == OP_EMIT_GATE || ctrl.op == OP_EMIT_OPEN);

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (ctrl.op == OP_EMIT_GATE) begin
        out_data_r.gain            <= gain;
        out_data_r.segment         <= seg_r[SEG_OUT_W-1:0];
        out_data_r.segment_changed <= (seg_r[SEG_OUT_W-1:0] != last_seg_r);
      end else begin
        out_data_r.gain            <= UNITY;
        out_data_r.segment         <= last_seg_r;
        out_data_r.segment_changed <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.len_zero = (len_r == '0);
  assign status.cnt_zero = (n == '0);
  assign status.wid_zero = (w_r == '0);
  assign status.div_done = div_done;
  assign status.out_free = out_free;

endmodule

// ===== hdl/spge_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
module spge_seq
  import spge_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t status,
  output ctrl_t   ctrl
);

  localparam logic [PC_W-1:0] PC_START = PC_W'(0);
  localparam logic [PC_W-1:0] PC_GAIN  = PC_W'(21);
  localparam logic [PC_W-1:0] PC_OPEN  = PC_W'(22);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic [PC_W-1:0] pc_inc;
  ucode_t          word;
  logic            cond_ok;

  // Control store
  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{SEQ_BRANCH, COND_ALWAYS, PC_START, OP_NOP};
    unique case (pc)
      PC_W'(0):  w = '{SEQ_WAIT,   COND_IN,       PC_W'(1),  OP_CAPTURE};
      PC_W'(1):  w = '{SEQ_BRANCH, COND_LEN_ZERO, PC_OPEN,   OP_NOP};
      PC_W'(2):  w = '{SEQ_NEXT,   COND_ALWAYS,   PC_START,  OP_DIV_PHASE};
      PC_W'(3):  w = '{SEQ_WAIT,   COND_DIV_DONE, PC_W'(4),  OP_NOP};
      PC_W'(4):  w = '{SEQ_NEXT,   COND_ALWAYS,   PC_START,  OP_ST_PHASE};
      PC_W'(5):  w = '{SEQ_BRANCH, COND_CNT_ZERO, PC_OPEN,   OP_NOP};
      PC_W'(6):  w = '{SEQ_NEXT,   COND_ALWAYS,   PC_START,  OP_MUL_PN};
      PC_W'(7):  w = '{SEQ_NEXT,   COND_ALWAYS,   PC_START,  OP_DIV_SEG};
      PC_W'(8):  w = '{SEQ_WAIT,   COND_DIV_DONE, PC_W'(9),  OP_NOP};
      PC_W'(9):  w = '{SEQ_NEXT,   COND_ALWAYS,   PC_START,  OP_ST_SEG};
      PC_W'(10): w = '{SEQ_NEXT,   COND_ALWAYS,   PC_START,  OP_DIV_WID};
      PC_W'(11): w = '{SEQ_WAIT,   COND_DIV_DONE, PC_W'(12), OP_NOP};
      PC_W'(12): w = '{SEQ_NEXT,   COND_ALWAYS,   PC_START,  OP_ST_WID};
      PC_W'(13): w = '{SEQ_BRANCH, COND_WID_ZERO, PC_GAIN,   OP_NOP};
      PC_W'(14): w = '{SEQ_NEXT,   COND_ALWAYS,   PC_START,  OP_DIV_OFS};
      PC_W'(15): w = '{SEQ_WAIT,   COND_DIV_DONE, PC_W'(16), OP_NOP};
      PC_W'(16): w = '{SEQ_NEXT,   COND_ALWAYS,   PC_START,  OP_ST_OFS};
      PC_W'(17): w = '{SEQ_NEXT,   COND_ALWAYS,   PC_START,  OP_MUL_WB};
      PC_W'(18): w = '{SEQ_NEXT,   COND_ALWAYS,   PC_START,  OP_DIV_RAMP};
      PC_W'(19): w = '{SEQ_WAIT,   COND_DIV_DONE, PC_W'(20), OP_NOP};
      PC_W'(20): w = '{SEQ_NEXT,   COND_ALWAYS,   PC_START,  OP_ST_RAMP};
      PC_W'(21): w = '{SEQ_WAIT,   COND_OUT_FREE, PC_START,  OP_EMIT_GATE};
      PC_W'(22): w = '{SEQ_WAIT,   COND_OUT_FREE, PC_START,  OP_EMIT_OPEN};
      default:   w = '{SEQ_BRANCH, COND_ALWAYS,   PC_START,  OP_NOP};
    endcase
    return w;
  endfunction

  assign word   = ucode_rom(pc_r);
  assign pc_inc = pc_r + PC_W'(1);

  // Evaluate the step's condition
  always_comb begin
    unique case (word.cond)
      COND_ALWAYS:   cond_ok = 1'b1;
      COND_IN:       cond_ok = in_valid;
      COND_LEN_ZERO: cond_ok = status.len_zero;
      COND_CNT_ZERO: cond_ok = status.cnt_zero;
      COND_WID_ZERO: cond_ok = status.wid_zero;
      COND_DIV_DONE: cond_ok = status.div_done;
      COND_OUT_FREE: cond_ok = status.out_free;
      default:       cond_ok = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    unique case (word.mode)
      SEQ_NEXT:   pc_nxt = pc_inc;
      SEQ_BRANCH: pc_nxt = cond_ok ? word.target : pc_inc;
      SEQ_WAIT:   pc_nxt = cond_ok ? word.target : pc_r;
      default:    pc_nxt = PC_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_START;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // A waiting step acts only in the cycle its condition holds
  assign ctrl.op   = word.op;
  assign ctrl.fire = (word.mode != SEQ_WAIT) | cond_ok;

endmodule

// ===== hdl/step_pattern_gate_envelope.sv =====
// Top level of the step pattern gate envelope: sequencer, datapath and checks.
//
//   channel  | ports                                | moves
//   ---------+--------------------------------------+------------------------------
//   input    | in_valid, in_stall, in_data          | sample_index, resync
//   result   | out_valid, out_stall, out_data       | gain, segment, segment_changed
//   config   | cfg_we, cfg_index, cfg_data          | one register per write
//
// A transaction with nonzero beat length, segment count and segment width runs the
// microcode steps and five passes of the shared one-bit-per-cycle divider (phase,
// segment, width, offset, ramp), which sets the rate; the next input is taken only
// after the result of the last one is emitted. Zero beat length or segment count skips
// to an open-gate result; zero segment width skips the offset and ramp passes. Reset is synchronous; no clearing pass.
// A stalled result holds in the output register while the next input is taken.
`include "assert_macros.svh"

module step_pattern_gate_envelope
  import spge_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_t   ctrl;
  status_t status;

  spge_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  spge_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Take input only at the capture step
  assign in_stall = (ctrl.op != OP_CAPTURE);

  // Checks on the sequencing
  `SPGE_ASSERT_NXT(a_accept_then_busy, clk, rst_n, in_valid && !in_stall, in_stall, "double accept")
  `SPGE_ASSERT_IMP(a_div_busy_stalls, clk, rst_n, !status.div_done, in_stall, "open while dividing")
  `SPGE_ASSERT_IMP(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall), "idle rise")

endmodule

// ===== test/step_pattern_gate_envelope_tb.sv =====
// Self-checking testbench for the step pattern gate envelope with its own gain predictor.
module step_pattern_gate_envelope_tb;
  import spge_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 800;
  localparam int SETTLE       = 200;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 100;
  localparam int SHOWN_FAULTS = 10;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    cfg_reg_t              target_reg;
    logic [CFG_DATA_W-1:0] value;
    in_item_t              sample;
    bit                    typed;
    out_item_t             want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of the registers and state
  logic [LEN_W-1:0]  beat_len;
  logic [CNT_W-1:0]  seg_count;
  logic [PAT_W-1:0]  gate_pattern;
  logic [BLUR_W-1:0] ramp_blur;
  logic [IDX_W-1:0]  beat_anchor;
  logic [3:0]        last_seg;

  out_item_t awaited_gates[$];
  plan_row_t plan[$];
  int        fault_count;
  int        cycle_count;
  bit        quiet;
  bit        hold_req;

  step_pattern_gate_envelope DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic pattern_open(logic [31:0] idx);
    if (idx >= 32'd16) return 1'b0;
    return gate_pattern[idx[3:0]];
  endfunction

  // Compute the gain, segment and change flag for one accepted sample; advance state.
  function automatic out_item_t predict_gate(in_item_t it);
    logic [31:0] phase;
    logic [31:0] n;
    logic [31:0] seg_full;
    logic [31:0] seg_w;
    logic [31:0] ofs;
    logic [63:0] ratio;
    logic [BLUR_W-1:0] b;
    logic [GAIN_W-1:0] q;
    logic cur_open;
    logic prev_open;
    out_item_t res;
    res.gain = UNITY;
    res.segment = last_seg;
    res.segment_changed = 1'b0;
    // Zero beat length: no state change at all
    if (beat_len == '0) return res;
    phase = (it.sample_index - beat_anchor) % 32'(beat_len);
    if (it.resync) beat_anchor = it.sample_index;
    n = (seg_count > MAX_SEGMENTS_DEF) ? 32'(MAX_SEGMENTS_DEF) : 32'(seg_count);
    // Zero count: gate open, anchor already moved
    if (n == 0) return res;
    seg_full = 32'((64'(phase) * 64'(n)) / 64'(beat_len));
    seg_w = 32'(beat_len) / n;
    if (seg_w == 0) begin
      q = UNITY;
    end else begin
      ofs = phase % seg_w;
      b = (ramp_blur < BLUR_FLOOR) ? BLUR_FLOOR : ramp_blur;
      ratio = (64'(ofs) << 31) / (64'(seg_w) * 64'(b));
      q = (ratio > 64'(UNITY)) ? UNITY : ratio[GAIN_W-1:0];
    end
    cur_open = pattern_open(seg_full);
    prev_open = pattern_open((seg_full == 0) ? n - 1 : seg_full - 1);
    if (cur_open) begin
      res.gain = prev_open ? UNITY : q;
    end else begin
      res.gain = prev_open ? UNITY - q : '0;
    end
    res.segment = seg_full[3:0];
    res.segment_changed = (seg_full[3:0] != last_seg);
    last_seg = seg_full[3:0];
    return res;
  endfunction

  function automatic plan_row_t cfg_row(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    plan_row_t row;
    row = '{kind: ROW_CFG, target_reg: r, value: v, sample: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t item_row(logic [IDX_W-1:0] idx, logic rs);
    plan_row_t row;
    row = '{kind: ROW_ITEM, target_reg: CFG_BEAT_LENGTH, value: '0,
            sample: '{sample_index: idx, resync: rs}, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t typed_row(logic [IDX_W-1:0] idx, logic rs,
                                          logic [GAIN_W-1:0] g, logic [3:0] s, logic c);
    plan_row_t row;
    row = item_row(idx, rs);
    row.typed = 1'b1;
    row.want = '{gain: g, segment: s, segment_changed: c};
    return row;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  task automatic note_fault(string msg);
    if (fault_count < SHOWN_FAULTS) $display("%s", msg);
    fault_count++;
  endtask

  // Offer one transaction, hold it until accepted, then maybe idle a burst.
  task automatic push_sample(in_item_t it, bit typed, out_item_t want);
    out_item_t pred;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_gate(it);
    awaited_gates.insert(awaited_gates.size(), typed ? want : pred);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_gates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (r)
      CFG_BEAT_LENGTH:   beat_len = v[LEN_W-1:0];
      CFG_SEGMENT_COUNT: seg_count = v[CNT_W-1:0];
      CFG_PATTERN:       gate_pattern = v[PAT_W-1:0];
      CFG_BLUR:          ramp_blur = v[BLUR_W-1:0];
      default: ;
    endcase
  endtask

  // Pick a random setting, then walk the beat with mostly small steps.
  task automatic random_phase(int count, bit with_hold);
    logic [31:0] pos;
    logic [31:0] span;
    logic [CFG_DATA_W-1:0] v;
    in_item_t it;
    int k;
    int sel;
    case ($urandom_range(0, 15))
      0:             v = '0;
      1:             v = 24'hFFFFFF;
      2, 3, 4, 5:    v = CFG_DATA_W'($urandom_range(1, 64));
      6, 7, 8, 9, 10: v = CFG_DATA_W'($urandom_range(100, 5000));
      default:       v = CFG_DATA_W'($urandom_range(5000, 200000));
    endcase
    write_reg(CFG_BEAT_LENGTH, v);
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = CFG_DATA_W'($urandom_range(17, 31));
      default: v = CFG_DATA_W'($urandom_range(1, 16));
    endcase
    write_reg(CFG_SEGMENT_COUNT, v);
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = 24'h00FFFF;
      default: v = CFG_DATA_W'($urandom_range(0, 65535));
    endcase
    write_reg(CFG_PATTERN, v);
    case ($urandom_range(0, 7))
      0:       v = CFG_DATA_W'($urandom_range(0, 65));
      1:       v = 24'd65536;
      2:       v = CFG_DATA_W'($urandom_range(65537, 131071));
      default: v = CFG_DATA_W'($urandom_range(66, 65535));
    endcase
    write_reg(CFG_BLUR, v);
    pos = $urandom;
    span = 32'(beat_len) / 8 + 1;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) pos = $urandom;
      else if (sel < 10) pos = pos + 1;
      else pos = pos + $urandom_range(1, span);
      it.sample_index = pos;
      it.resync = ($urandom_range(0, 11) == 0);
      push_sample(it, 1'b0, '0);
      if (with_hold && k == 1) hold_req = 1'b1;
    end
  endtask

  // Check each result transaction and drive the receiver stall.
  initial begin : result_side
    int burst;
    bit hold_done;
    out_item_t want;
    burst = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (awaited_gates.size() == 0) begin
          note_fault($sformatf("unexpected result: gain %0d seg %0d chg %0d",
                               out_data.gain, out_data.segment, out_data.segment_changed));
        end else begin
          want = awaited_gates.pop_front();
          if (out_data.gain !== want.gain || out_data.segment !== want.segment ||
              out_data.segment_changed !== want.segment_changed) begin
            note_fault($sformatf(
              "gate mismatch: want gain %0d seg %0d chg %0d, got gain %0d seg %0d chg %0d",
              want.gain, want.segment, want.segment_changed,
              out_data.gain, out_data.segment, out_data.segment_changed));
          end
        end
      end
      // Long hold-off once, so the block fills and stalls its input
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        burst = HOLD_CYCLES;
      end
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(0, 5);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Bound the run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("step_pattern_gate_envelope_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    int i;
    int p;
    plan_row_t row;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BEAT_LENGTH;
    cfg_data <= '0;
    fault_count = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    beat_len = LEN_RESET;
    seg_count = CNT_RESET;
    gate_pattern = PAT_RESET;
    ramp_blur = BLUR_RESET;
    beat_anchor = '0;
    last_seg = '0;

    // Reset-state walk across one beat, then anchor moves and wrap
    add_row(typed_row(32'd0, 1'b0, UNITY, 4'd0, 1'b0));
    add_row(typed_row(32'd3000, 1'b0, UNITY, 4'd1, 1'b1));
    add_row(typed_row(32'd47999, 1'b0, UNITY, 4'd15, 1'b1));
    add_row(typed_row(32'd48000, 1'b1, UNITY, 4'd0, 1'b1));
    add_row(typed_row(32'd48001, 1'b0, UNITY, 4'd0, 1'b0));
    add_row(item_row(32'hFFFFFFFF, 1'b1));
    add_row(item_row(32'h00000000, 1'b0));
    // Zero count: gate open, anchor follows resync
    add_row(cfg_row(CFG_SEGMENT_COUNT, 24'd0));
    add_row(typed_row(32'd12345, 1'b1, UNITY, 4'd0, 1'b0));
    // Count above maximum clamps to sixteen
    add_row(cfg_row(CFG_SEGMENT_COUNT, 24'd31));
    add_row(typed_row(32'd12345, 1'b0, UNITY, 4'd0, 1'b0));
    // Zero beat length: state frozen, resync ignored
    add_row(cfg_row(CFG_BEAT_LENGTH, 24'd0));
    add_row(typed_row(32'hFFFFFFFF, 1'b1, UNITY, 4'd0, 1'b0));
    // Segment width zero: full ramp on a rising edge
    add_row(cfg_row(CFG_BEAT_LENGTH, 24'd1));
    add_row(cfg_row(CFG_PATTERN, 24'h000001));
    add_row(typed_row(32'd77, 1'b1, UNITY, 4'd0, 1'b0));
    // Longest beat, blur at unity
    add_row(cfg_row(CFG_BEAT_LENGTH, 24'hFFFFFF));
    add_row(cfg_row(CFG_PATTERN, 24'h00A5C3));
    add_row(cfg_row(CFG_BLUR, 24'd65536));
    add_row(item_row(32'h00100000, 1'b0));
    add_row(item_row(32'h00A00000, 1'b0));
    add_row(item_row(32'h00FFFFFF, 1'b0));
    add_row(item_row(32'h7FFFFFFF, 1'b0));
    add_row(item_row(32'h80000000, 1'b1));
    // Blur below the floor, then above unity
    add_row(cfg_row(CFG_BLUR, 24'd0));
    add_row(item_row(32'h80000100, 1'b0));
    add_row(cfg_row(CFG_BLUR, 24'h01FFFF));
    add_row(item_row(32'h80100010, 1'b0));
    // Short beat, three segments: closed, rising and falling edges
    add_row(cfg_row(CFG_BEAT_LENGTH, 24'd100));
    add_row(cfg_row(CFG_SEGMENT_COUNT, 24'd3));
    add_row(cfg_row(CFG_PATTERN, 24'h000002));
    add_row(cfg_row(CFG_BLUR, 24'd16384));
    add_row(item_row(32'h80000000, 1'b0));
    add_row(item_row(32'h80000022, 1'b0));
    add_row(item_row(32'h8000002A, 1'b0));
    add_row(item_row(32'h80000043, 1'b0));
    add_row(item_row(32'h80000063, 1'b0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (i = 0; i < plan.size(); i++) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.target_reg, row.value);
      end else begin
        push_sample(row.sample, row.typed, row.want);
      end
    end

    // Random settings; no idling in the last phase
    for (p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) quiet = 1'b1;
      random_phase(PHASE_ITEMS, p == 2);
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (fault_count == 0) begin
      $display("step_pattern_gate_envelope_tb: PASS");
    end else begin
      $display("step_pattern_gate_envelope_tb: FAIL");
    end
    $finish;
  end

endmodule
